/* sv/qws_pkg.sv */
// shared types and constants of the quoted word splitter
package qws_pkg;

   localparam int WORD_LIMIT_DEFAULT = 32;

   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 5;
   localparam int ERR_W   = 2;

   localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_SQUOTE = 8'h27;
   localparam logic [CHAR_W-1:0] CHAR_DQUOTE = 8'h22;

   localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
   localparam logic [ERR_W-1:0] ERR_WORDS  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_SQUOTE = 2'd2;
   localparam logic [ERR_W-1:0] ERR_DQUOTE = 2'd3;

   typedef enum logic [2:0] {
      MODE_WAIT    = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_SQUOTE  = 3'd2,
      MODE_DQUOTE  = 3'd3,
      MODE_DISCARD = 3'd4
   } mode_type;

   typedef struct packed {
      logic                char_valid;
      logic [CHAR_W-1:0]   out_char;
      logic [INDEX_W-1:0]  word_index;
      logic                word_end;
      logic                line_end;
      logic [INDEX_W-1:0]  word_count;
      logic [ERR_W-1:0]    error_code;
   } result_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

/* sv/quoted_word_splitter.sv */
// quoted word splitter: splits a nul-terminated command line into words
//
// req channel: one character per beat on req_tdata; nul ends the line.
// rsp channel: at most one result word per character. tuser flags a kept
//   character (bit 0) and a committed word (bit 1); tlast marks line end,
//   and then tdata carries the word count or an error code.
// opening and closing quote characters, whitespace between words, and
//   characters discarded after a word-count error give no result.
// results are registered: each shows on rsp the cycle after its character.
// throughput: one character per cycle while results are drained; the
//   per-character update of scan mode and word counter is combinational.
// stall: the result register holds while rsp_tready is low; req_tready
//   drops only when that register is full and not being taken, so the
//   block keeps streaming whenever the result is drained in the same cycle.
// reset: synchronous, active high; clears the scan mode, the word counter
//   and the result valid, so the next character starts a new line.
module quoted_word_splitter
   import qws_pkg::*;
#(
   parameter int WORD_LIMIT = WORD_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_char, [12:8] word_index,
                                    // [17:13] word_count, [19:18] error_code
   output logic [1:0]  rsp_tuser,   // [0] char_valid, [1] word_end
   output logic        rsp_tlast    // line_end
);

   localparam int CNT_W = (WORD_LIMIT > 1) ? $clog2(WORD_LIMIT) : 1;

   mode_type           mode_ff, mode_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               have_result;

   logic               accept;
   logic [CHAR_W-1:0]  c;
   logic               c_nul, c_blank, c_squote, c_dquote;
   logic [CNT_W:0]     next_cnt;
   logic               over_limit;
   logic [8:0]         seen_wide, next_wide;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;

   assign c        = req_tdata;
   assign c_nul    = (c == CHAR_NUL);
   assign c_blank  = is_blank(c);
   assign c_squote = (c == CHAR_SQUOTE);
   assign c_dquote = (c == CHAR_DQUOTE);

   assign next_cnt   = {1'b0, seen_ff} + (CNT_W+1)'(1);
   assign over_limit = (next_cnt >= (CNT_W+1)'(WORD_LIMIT));
   assign seen_wide  = 9'(seen_ff);
   assign next_wide  = 9'(next_cnt);

   // next scan state
   always_comb begin
      mode_in = mode_ff;
      seen_in = seen_ff;
      unique case (mode_ff)
         MODE_DISCARD: begin
            if (c_nul) begin
               mode_in = MODE_WAIT;
               seen_in = '0;
            end
         end
         MODE_SQUOTE, MODE_DQUOTE: begin
            if ((mode_ff == MODE_SQUOTE) ? c_squote : c_dquote) begin
               mode_in = MODE_WORD;
            end else if (c_nul) begin
               mode_in = MODE_WAIT;
               seen_in = '0;
            end
         end
         default: begin
            // waiting and in-word share this; nul is handled first, then
            // blanks, which end a word only when in-word
            priority if (c_nul) begin
               mode_in = MODE_WAIT;
               seen_in = '0;
            end else if (c_blank) begin
               if (mode_ff != MODE_WORD) begin
                  mode_in = MODE_WAIT;
               end else if (over_limit) begin
                  mode_in = MODE_DISCARD;
               end else begin
                  mode_in = MODE_WAIT;
                  seen_in = next_cnt[CNT_W-1:0];
               end
            end else if (c_squote) begin
               mode_in = MODE_SQUOTE;
            end else if (c_dquote) begin
               mode_in = MODE_DQUOTE;
            end else begin
               mode_in = MODE_WORD;
            end
         end
      endcase
   end

   // result of this character
   always_comb begin
      rsp_in      = '0;
      have_result = 1'b0;
      unique case (mode_ff)
         MODE_DISCARD: begin
            have_result = 1'b0;
         end
         MODE_SQUOTE, MODE_DQUOTE: begin
            if ((mode_ff == MODE_SQUOTE) ? c_squote : c_dquote) begin
               have_result = 1'b0;
            end else if (c_nul) begin
               have_result       = 1'b1;
               rsp_in.line_end   = 1'b1;
               rsp_in.error_code = (mode_ff == MODE_SQUOTE) ? ERR_SQUOTE : ERR_DQUOTE;
            end else begin
               have_result       = 1'b1;
               rsp_in.char_valid = 1'b1;
               rsp_in.out_char   = c;
               rsp_in.word_index = seen_wide[INDEX_W-1:0];
            end
         end
         default: begin
            priority if (c_nul && (mode_ff != MODE_WORD)) begin
               have_result       = 1'b1;
               rsp_in.line_end   = 1'b1;
               rsp_in.word_count = seen_wide[INDEX_W-1:0];
            end else if (c_blank && (mode_ff != MODE_WORD)) begin
               have_result = 1'b0;
            end else if (c_nul || c_blank) begin
               // commit the word, or flag a word error; nul also ends the line
               have_result = 1'b1;
               if (over_limit) begin
                  rsp_in.line_end   = 1'b1;
                  rsp_in.error_code = ERR_WORDS;
               end else begin
                  rsp_in.word_end   = 1'b1;
                  rsp_in.word_index = seen_wide[INDEX_W-1:0];
                  rsp_in.line_end   = c_nul;
                  rsp_in.word_count = c_nul ? next_wide[INDEX_W-1:0] : '0;
               end
            end else if (c_squote || c_dquote) begin
               have_result = 1'b0;
            end else begin
               have_result       = 1'b1;
               rsp_in.char_valid = 1'b1;
               rsp_in.out_char   = c;
               rsp_in.word_index = seen_wide[INDEX_W-1:0];
            end
         end
      endcase
   end

   assign rsp_valid_in = accept ? have_result : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff <= mode_in;
            seen_ff <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && have_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.error_code, rsp_ff.word_count,
                        rsp_ff.word_index, rsp_ff.out_char};
   assign rsp_tuser  = {rsp_ff.word_end, rsp_ff.char_valid};
   assign rsp_tlast  = rsp_ff.line_end;

`ifndef SYNTH
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("req_tready low with empty result register");

   a_char_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.char_valid) |-> (!rsp_ff.word_end && !rsp_ff.line_end))
      else $error("kept character combined with word or line end");

   a_error_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.error_code != ERR_NONE)
         |-> (rsp_ff.line_end && rsp_ff.word_count == '0 && !rsp_ff.word_end))
      else $error("error result without line end or with a word count");

   // a word-count error on a blank goes to discard and keeps the counter
   a_seen_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && have_result && rsp_in.line_end && mode_in != MODE_DISCARD)
         |=> (seen_ff == '0))
      else $error("word counter not cleared at line end");
`endif

endmodule
